>>> rtl/four_level_page_map_writer_unit_macros.svh
// Assertion macros for the four-level page map writer.
// Used by the top level only; needs nothing else.
`ifndef FOUR_LEVEL_PAGE_MAP_WRITER_UNIT_MACROS_SVH
`define FOUR_LEVEL_PAGE_MAP_WRITER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication
`define FPMW_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fpmw: same-cycle check failed");
// Next-cycle implication
`define FPMW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fpmw: next-cycle check failed");
`else
`define FPMW_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FPMW_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/fpmw_pkg.sv
// Shared constants and types of the four-level page map writer.
// No dependencies; imported by the add/subtract unit and the top level.
package fpmw_pkg;

    // Table store geometry
    localparam int TABLE_FRAMES = 64;
    localparam int IDX_W        = 9;
    localparam int ENTRIES      = 1 << IDX_W;
    localparam int FRAME_W      = $clog2(TABLE_FRAMES);
    localparam int ADDR_W       = FRAME_W + IDX_W;
    localparam int STORE_DEPTH  = TABLE_FRAMES * ENTRIES;
    localparam int NFREE_W      = $clog2(TABLE_FRAMES + 1);

    // Address and entry widths
    localparam int VA_W       = 48;
    localparam int PA_W       = 52;
    localparam int BASE_W     = 40;
    localparam int PAGE_SHIFT = 12;
    localparam int LINK_W     = BASE_W + 1;
    localparam int ENTRY_W    = LINK_W + PAGE_SHIFT;
    localparam int FLAG_W     = 3;

    localparam logic [FLAG_W-1:0] LINK_FLAGS = 3'd7;

    // Channel widths
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 56;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOFRAME = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    // Command to the shared add/subtract unit
    typedef struct packed {
        logic              sub;
        logic [LINK_W-1:0] a;
        logic [LINK_W-1:0] b;
    } fpmw_op_t;

endpackage

>>> rtl/fpmw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpmw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/fpmw_addsub.sv
// Shared add/subtract unit: frame range check and link address build.
// Depends on fpmw_pkg.
module fpmw_addsub
    import fpmw_pkg::*;
(
    input  fpmw_op_t          op,
    output logic [LINK_W:0]   res
);

    // Top bit is the carry on add, the borrow on subtract
    always_comb begin
        if (op.sub) begin
            res = {1'b0, op.a} - {1'b0, op.b};
        end else begin
            res = {1'b0, op.a} + {1'b0, op.b};
        end
    end

endmodule

>>> rtl/four_level_page_map_writer_unit.sv
// Four-level page map writer: maps one virtual page per input word.
// Input s_ channel word: virtual address and physical address. Each word walks
// a four-level table held in an on-chip store of TABLE_FRAMES frames of 512
// entries (root at frame 0), allocates missing tables from a bump allocator,
// and writes the leaf entry. One result word per input word leaves on m_.
// cfg_we/cfg_wdata set the base frame number; write it only while idle.
// Flow per word: each level's link is read from the registered-read store,
// then checked in the shared add/subtract unit. When a link is missing or all
// three exist, the free-frame check follows, then one allocation per missing
// table, the leaf write and the output load. A link that points outside the
// store, or too few free frames, ends the walk early with an error status.
// The sequencer then returns to idle before it takes the next word.
// s_tready is high only while idle; a new word may be taken while a result
// still waits on m_. If the receiver stalls, the finished result waits in the
// sequencer until the output register frees up.
// Reset: the store is swept to zero, one entry a cycle, over its TABLE_FRAMES * 512
// entries (32768 at 64 frames) with s_tready low; configuration writes are
// still taken. The allocator restarts at frame 1 and the base returns to 0.
`include "four_level_page_map_writer_unit_macros.svh"
module four_level_page_map_writer_unit
    import fpmw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [BASE_W-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // virt_addr[47:0], phys_addr[99:48], zero pad[103:100]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // tables_created[1:0], leaf_entry[53:2], status[55:54]
    output logic [M_DATA_W-1:0] m_tdata
);

    // Sequencer states
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_EVAL  = 4'd3;
    localparam logic [3:0] ST_CHECK = 4'd4;
    localparam logic [3:0] ST_ALLOC = 4'd5;
    localparam logic [3:0] ST_LEAF  = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    logic [3:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [BASE_W-1:0]   base_reg;
    logic [VA_W-1:0]     va_reg, va_next;
    logic [PA_W-1:0]     pa_reg, pa_next;
    logic [1:0]          level_reg, level_next;
    logic [FRAME_W-1:0]  table_reg, table_next;
    logic [1:0]          missing_reg, missing_next;
    logic [NFREE_W-1:0]  nfree_reg, nfree_next;
    logic [1:0]          res_tc_reg, res_tc_next;
    logic [PA_W-1:0]     res_leaf_reg, res_leaf_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [IDX_W-1:0]    idx_sel;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    fpmw_op_t            op;
    logic [LINK_W:0]     op_res;

    // Table store
    fpmw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr ({table_reg, idx_sel}),
        .rdata (ram_rdata)
    );

    // Shared arithmetic
    fpmw_addsub u_addsub (
        .op  (op),
        .res (op_res)
    );

    // Pick the table index of the current level
    always_comb begin
        case (level_reg)
            2'd0:    idx_sel = va_reg[47:39];
            2'd1:    idx_sel = va_reg[38:30];
            2'd2:    idx_sel = va_reg[29:21];
            default: idx_sel = va_reg[20:12];
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        level_next      = level_reg;
        table_next      = table_reg;
        missing_next    = missing_reg;
        nfree_next      = nfree_reg;
        res_tc_next     = res_tc_reg;
        res_leaf_next   = res_leaf_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = {table_reg, idx_sel};
        ram_wdata       = '0;
        op              = '0;

        // Drop the output word once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    va_next      = s_tdata[VA_W-1:0];
                    pa_next      = s_tdata[VA_W+PA_W-1:VA_W];
                    level_next   = 2'd0;
                    table_next   = '0;
                    missing_next = 2'd0;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // Frame number of the link, relative to the store base
                op.sub = 1'b1;
                op.a   = ram_rdata[ENTRY_W-1:PAGE_SHIFT];
                op.b   = LINK_W'(base_reg);
                if (!ram_rdata[0]) begin
                    missing_next = 2'd3 - level_reg;
                    state_next   = ST_CHECK;
                end else if (op_res[LINK_W] ||
                             op_res[LINK_W-1:0] >= LINK_W'(TABLE_FRAMES)) begin
                    res_tc_next     = 2'd0;
                    res_leaf_next   = '0;
                    res_status_next = STAT_RANGE;
                    state_next      = ST_DONE;
                end else begin
                    table_next = op_res[FRAME_W-1:0];
                    level_next = level_reg + 2'd1;
                    state_next = (level_reg == 2'd2) ? ST_CHECK : ST_READ;
                end
            end
            ST_CHECK: begin
                if (nfree_reg > NFREE_W'(TABLE_FRAMES) ||
                    NFREE_W'(missing_reg) > NFREE_W'(TABLE_FRAMES) - nfree_reg) begin
                    res_tc_next     = 2'd0;
                    res_leaf_next   = '0;
                    res_status_next = STAT_NOFRAME;
                    state_next      = ST_DONE;
                end else begin
                    state_next = (level_reg == 2'd3) ? ST_LEAF : ST_ALLOC;
                end
            end
            ST_ALLOC: begin
                // Link a fresh frame: (base + frame) << 12 | flags
                op.sub     = 1'b0;
                op.a       = LINK_W'(base_reg);
                op.b       = LINK_W'(nfree_reg);
                ram_we     = 1'b1;
                ram_wdata  = {op_res[LINK_W-1:0], {(PAGE_SHIFT-FLAG_W){1'b0}}, LINK_FLAGS};
                table_next = nfree_reg[FRAME_W-1:0];
                nfree_next = nfree_reg + 1'b1;
                level_next = level_reg + 2'd1;
                if (level_reg == 2'd2) begin
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF: begin
                ram_we          = 1'b1;
                ram_wdata       = ENTRY_W'(pa_reg | PA_W'(LINK_FLAGS));
                res_tc_next     = missing_reg;
                res_leaf_next   = pa_reg | PA_W'(LINK_FLAGS);
                res_status_next = STAT_OK;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_tdata_next = {res_status_reg, res_leaf_reg, res_tc_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            nfree_reg    <= NFREE_W'(1);
            m_valid_reg  <= 1'b0;
            base_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            nfree_reg    <= nfree_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        va_reg         <= va_next;
        pa_reg         <= pa_next;
        level_reg      <= level_next;
        table_reg      <= table_next;
        missing_reg    <= missing_next;
        res_tc_reg     <= res_tc_next;
        res_leaf_reg   <= res_leaf_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // Checks
    `FPMW_ASSERT_IMP(a_idle_no_write, aclk, aresetn, state_reg == ST_IDLE, !ram_we)
    `FPMW_ASSERT_IMP(a_alloc_in_range, aclk, aresetn, state_reg == ST_ALLOC,
                     nfree_reg < NFREE_W'(TABLE_FRAMES))
    `FPMW_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

>>> tb/four_level_page_map_writer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for four_level_page_map_writer_unit: directed and random map requests,
// checked word by word against a model of the table walk. Needs fpmw_pkg and the RTL.
module four_level_page_map_writer_unit_tb;
    import fpmw_pkg::*;

    localparam int PHASES        = 5;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 60;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int IDLE_PCT      = 22;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [PA_W-1:0] pa;
        logic [VA_W-1:0] va;
    } map_req_t;

    // same layout as m_tdata: made in the low bits, status on top
    typedef struct packed {
        logic [1:0]      status;
        logic [PA_W-1:0] leaf;
        logic [1:0]      made;
    } map_result_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [BASE_W-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // virt_addr[47:0], phys_addr[99:48], zero pad[103:100]
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // tables_created[1:0], leaf_entry[53:2], status[55:54]
    logic [M_DATA_W-1:0] m_tdata;

    // model copy of the table store, allocator and base register
    logic [63:0]       page_store [STORE_DEPTH];
    int unsigned       next_frame = 1;
    logic [BASE_W-1:0] base_frame = '0;

    map_req_t    pending_maps [$];
    map_result_t due_results [$];
    int unsigned words_offered = 0;
    int unsigned words_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned cycles        = 0;
    int unsigned hold_left     = 0;
    bit          hold_used     = 1'b0;
    bit          steady        = 1'b0;

    four_level_page_map_writer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Walk the model tables for one request, allocate and link, and return the result word
    function automatic map_result_t map_page(input logic [VA_W-1:0] va,
                                             input logic [PA_W-1:0] pa);
        map_result_t      res;
        logic [IDX_W-1:0] idx [4];
        logic [63:0]      ent;
        logic [63:0]      frm;
        logic [63:0]      base_ext;
        int unsigned      tbl;
        int unsigned      missing;
        int unsigned      fresh;
        int               lvl;
        res      = '0;
        base_ext = 64'(base_frame);
        tbl      = 0;
        missing  = 0;
        for (lvl = 0; lvl < 4; lvl++)
            idx[lvl] = IDX_W'(va >> (PAGE_SHIFT + IDX_W * (3 - lvl)));
        // follow present links; the flag bits fall off in the shift
        for (lvl = 0; lvl < 3; lvl++) begin
            ent = page_store[tbl * ENTRIES + idx[lvl]];
            if (!ent[0]) begin
                missing = 3 - lvl;
                break;
            end
            frm = ent >> PAGE_SHIFT;
            if (frm < base_ext || frm - base_ext >= 64'(TABLE_FRAMES)) begin
                res.status = STAT_RANGE;
                return res;
            end
            tbl = int'(frm - base_ext);
        end
        // refuse the whole request when the allocator cannot cover it
        if (next_frame > TABLE_FRAMES || missing > TABLE_FRAMES - next_frame) begin
            res.status = STAT_NOFRAME;
            return res;
        end
        for (lvl = 3 - missing; lvl < 3; lvl++) begin
            fresh = next_frame;
            next_frame++;
            page_store[tbl * ENTRIES + idx[lvl]] =
                ((base_ext + 64'(fresh)) << PAGE_SHIFT) | 64'(LINK_FLAGS);
            tbl = fresh;
        end
        page_store[tbl * ENTRIES + idx[3]] = {12'b0, pa} | 64'(LINK_FLAGS);
        res.made   = 2'(missing);
        res.leaf   = pa | PA_W'(LINK_FLAGS);
        res.status = STAT_OK;
        return res;
    endfunction

    // Sample both channels and the register port at the rising edge
    always @(posedge aclk) begin : watch_ports
        map_result_t got;
        map_result_t want;
        map_req_t    req;
        if (aresetn) begin
            if (cfg_we)
                base_frame = cfg_wdata;
            // check each result word against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result word %h arrived with nothing expected", m_tdata);
                end else begin
                    want = due_results.pop_front();
                    if (got.made !== want.made || got.leaf !== want.leaf ||
                        got.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("map result %0d: expected made %0d leaf %h status %0d, got made %0d leaf %h status %0d",
                                     results_seen, want.made, want.leaf, want.status,
                                     got.made, got.leaf, got.status);
                    end
                end
            end
            // predict on every accepted request word
            if (s_tvalid && s_tready) begin
                req = s_tdata[VA_W+PA_W-1:0];
                due_results.push_back(map_page(req.va, req.pa));
                words_taken++;
            end
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present request words from the queue, with random gaps outside the steady phase
    always @(negedge aclk) begin : feed_requests
        map_req_t req;
        logic     valid_next;
        valid_next = s_tvalid;
        if (!aresetn) begin
            valid_next = 1'b0;
        end else if (!s_tvalid || words_taken == words_offered) begin
            if (pending_maps.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PCT)) begin
                req = pending_maps.pop_front();
                s_tdata <= {{(S_DATA_W - VA_W - PA_W){1'b0}}, req};
                words_offered++;
                valid_next = 1'b1;
            end else begin
                valid_next = 1'b0;
            end
        end
        s_tvalid <= valid_next;
    end

    // Accept result words with random stalls outside the steady phase and one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_used && results_seen >= HOLD_AFTER) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : run_phases
        logic [BASE_W-1:0] phase_base [PHASES];
        int                phase_items [PHASES];
        logic [IDX_W-1:0]  pool [4][3];
        logic [IDX_W-1:0]  idx [4];
        logic [PA_W-1:0]   pa;
        int                ph;
        int                n;
        int                l;
        foreach (page_store[i])
            page_store[i] = '0;

        // base settings per phase: zero, one, all ones, random, back to zero
        phase_base[0] = '0;
        phase_base[1] = BASE_W'(1);
        phase_base[2] = '1;
        phase_base[3] = {8'($urandom_range(255, 1)), 32'($urandom)};
        phase_base[4] = '0;
        phase_items   = '{400, 200, 100, 100, 540};

        // small index pools so most requests share tables
        for (l = 0; l < 4; l++) begin
            pool[l][0] = '0;
            pool[l][1] = '1;
            pool[l][2] = IDX_W'($urandom_range(ENTRIES - 2, 1));
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        for (ph = 0; ph <= PHASES; ph++) begin
            // drain before touching the base register or ending
            while (pending_maps.size() != 0 || words_taken != words_offered ||
                   due_results.size() != 0)
                @(negedge aclk);
            repeat (SETTLE_CYCLES) @(negedge aclk);
            if (ph == PHASES)
                break;

            steady    = (ph == 3);
            cfg_we    <= 1'b1;
            cfg_wdata <= phase_base[ph];
            @(negedge aclk);
            cfg_we    <= 1'b0;

            if (ph == 0) begin
                // fresh walk, then remaps that reuse zero to three levels
                pending_maps.push_back({52'h0, 48'h0});
                pending_maps.push_back({52'hF_FFFF_FFFF_FFFF, 48'h0});
                pending_maps.push_back({52'h0_0000_0000_1234, 48'hFFFF_FFFF_FFFF});
                pending_maps.push_back({52'hF_FFFF_FFFF_F000, 48'h0000_0000_0FFF});
                pending_maps.push_back({52'($urandom), 48'h0000_0000_1000});
                pending_maps.push_back({52'($urandom), 48'h0000_0020_0000});
                pending_maps.push_back({52'($urandom), 48'h0000_4000_0000});
                pending_maps.push_back({52'h5_5555_5555_5555, 48'hAAAA_AAAA_AAAA});
                pending_maps.push_back({52'hA_AAAA_AAAA_AAAA, 48'h5555_5555_5555});
                pending_maps.push_back({52'h0_0000_0000_0007, 48'h8000_0000_0000});
                pending_maps.push_back({52'h0_0000_0000_3000, 48'h0000_0000_2000});
            end

            for (n = 0; n < phase_items[ph]; n++) begin
                for (l = 0; l < 4; l++)
                    idx[l] = ($urandom_range(99) < 85) ? pool[l][$urandom_range(2)]
                                                       : IDX_W'($urandom_range(ENTRIES - 1));
                case ($urandom_range(9))
                    0:       pa = '0;
                    1:       pa = '1;
                    2:       pa = PA_W'($urandom_range(4095));
                    default: pa = PA_W'({$urandom, $urandom});
                endcase
                pending_maps.push_back({pa, idx[0], idx[1], idx[2], idx[3],
                                        12'($urandom)});
            end
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
